/* src/positional_insert_remove_array_defines.svh */
// Assertion macros shared by the positional insert/remove array modules.
`ifndef POSITIONAL_INSERT_REMOVE_ARRAY_DEFINES_SVH
`define POSITIONAL_INSERT_REMOVE_ARRAY_DEFINES_SVH
`ifndef SYNTHESIS
`define PIRA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PIRA_ASSERT_SAME(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define PIRA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PIRA_ASSERT(lbl, clk, rst, prop, msg)
`define PIRA_ASSERT_SAME(lbl, clk, rst, pre, post, msg)
`define PIRA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

/* src/pira_pkg.sv */
// Shared codes, field widths and control types of the positional insert/remove array.
`timescale 1ns / 1ps
package pira_pkg;

   localparam int CmdW      = 2;
   localparam int PosW      = 8;
   localparam int ValueW    = 32;
   localparam int StatusW   = 2;
   localparam int CountOutW = 5;
   localparam int CntMaxW   = 9;

   localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
   localparam logic [CmdW-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CmdW-1:0] CMD_READ   = 2'd2;

   localparam logic [StatusW-1:0] ST_OK    = 2'd0;
   localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
   localparam logic [StatusW-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic            ins;
      logic            rem;
      logic            rd_ok;
      logic            load;
      logic [PosW-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic [CntMaxW-1:0] count;
   } dp_stat_type;

endpackage

/* src/positional_insert_remove_array.sv */
// Top level of the positional insert/remove array.
`timescale 1ns / 1ps
// An ordered list of up to CAPACITY words held in a row of shifting cells. Each request
// word inserts, removes or reads at a position and gets exactly one response word with the
// read data, a status and the entry count after the operation. One request is taken per
// cycle; its response appears in the output register in the next cycle, and the next request
// is taken in the same cycle that this response is taken, so throughput is one word per
// cycle when the response side is ready. All cells shift in parallel as the request is taken.
module positional_insert_remove_array #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // pos[7:0], value[39:8]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // read_value[31:0], count[36:32], zero[39:37]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import pira_pkg::*;

   dp_cmd_type            dp_cmd;
   dp_stat_type           dp_stat;
   logic [ValueW-1:0]     read_value;
   logic [CountOutW-1:0]  count;

   pira_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .req_pos    (req_tdata[7:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_tuser),
      .dp_cmd     (dp_cmd),
      .dp_stat    (dp_stat)
   );

   pira_dp #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_tdata[39:8]),
      .dp_cmd         (dp_cmd),
      .dp_stat        (dp_stat),
      .rsp_read_value (read_value),
      .rsp_count      (count)
   );

   assign rsp_tdata = {3'b000, count, read_value};

endmodule

/* src/pira_ctrl.sv */
// Controller: output-register occupancy, operation decode and status code.
`timescale 1ns / 1ps
`include "positional_insert_remove_array_defines.svh"
module pira_ctrl #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pira_pkg::CmdW-1:0]     req_cmd,
   input  logic [pira_pkg::PosW-1:0]     req_pos,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pira_pkg::StatusW-1:0]  rsp_status,
   output pira_pkg::dp_cmd_type          dp_cmd,
   input  pira_pkg::dp_stat_type         dp_stat
);
   import pira_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_HOLD
   } state_type;

   state_type          state_ff, state_in;
   logic [StatusW-1:0] status_ff, status_in;
   logic               accept;
   logic               full;
   logic               pos_lt;
   logic               pos_gt;
   logic [CntMaxW-1:0] pos_ext;

   assign req_tready = (state_ff == S_IDLE) || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_HOLD);
   assign rsp_status = status_ff;

   assign pos_ext = CntMaxW'(req_pos);
   assign full    = (dp_stat.count == CntMaxW'(CAPACITY));
   assign pos_lt  = (pos_ext < dp_stat.count);
   assign pos_gt  = (pos_ext > dp_stat.count);

   always_comb begin
      dp_cmd       = '0;
      dp_cmd.load  = accept;
      dp_cmd.ins   = accept && (req_cmd == CMD_INSERT) && !full;
      dp_cmd.rem   = accept && (req_cmd == CMD_REMOVE) && pos_lt;
      dp_cmd.rd_ok = accept && (req_cmd == CMD_READ) && pos_lt;
      dp_cmd.idx   = ((req_cmd == CMD_INSERT) && pos_gt) ? PosW'(dp_stat.count) : req_pos;

      unique case (req_cmd)
         CMD_INSERT: begin
            status_in = full ? ST_FULL : ST_OK;
         end
         CMD_REMOVE, CMD_READ: begin
            status_in = pos_lt ? ST_OK : ST_RANGE;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase

      priority if (accept) begin
         state_in = S_HOLD;
      end else if (rsp_tready) begin
         state_in = S_IDLE;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            status_ff <= status_in;
         end
      end
   end

   `PIRA_ASSERT_SAME(a_full_status, clock, reset, rsp_tvalid && (status_ff == ST_FULL), full, "full status without full array")
   `PIRA_ASSERT(a_one_shift, clock, reset, !(dp_cmd.ins && dp_cmd.rem), "insert and remove together")
   `PIRA_ASSERT_SAME(a_range_read, clock, reset, dp_cmd.rd_ok || dp_cmd.rem, CntMaxW'(dp_cmd.idx) < dp_stat.count, "index beyond count")

endmodule

/* src/pira_dp.sv */
// Datapath: shifting entry cells, entry count and read word register.
`timescale 1ns / 1ps
`include "positional_insert_remove_array_defines.svh"
module pira_dp #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pira_pkg::ValueW-1:0]   req_value,
   input  pira_pkg::dp_cmd_type          dp_cmd,
   output pira_pkg::dp_stat_type         dp_stat,
   output logic [pira_pkg::ValueW-1:0]   rsp_read_value,
   output logic [pira_pkg::CountOutW-1:0] rsp_count
);
   import pira_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [DATA_WIDTH-1:0] entries_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] entries_in [CAPACITY];
   logic [CW-1:0]         count_ff, count_in;
   logic [ValueW-1:0]     read_value_ff, read_value_in;
   logic [IW-1:0]         idx;
   logic [DATA_WIDTH-1:0] word;

   assign idx  = dp_cmd.idx[IW-1:0];
   assign word = DATA_WIDTH'(req_value);

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
         if (dp_cmd.ins) begin
            if (IW'(i) == idx) begin
               entries_in[i] = word;
            end else if ((i > 0) && (IW'(i) > idx)) begin
               entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (dp_cmd.rem) begin
            if ((i < CAPACITY - 1) && (IW'(i) >= idx)) begin
               entries_in[i] = entries_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      priority if (dp_cmd.ins) begin
         count_in = count_ff + 1'b1;
      end else if (dp_cmd.rem) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
      read_value_in = dp_cmd.rd_ok ? ValueW'(entries_ff[idx]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (dp_cmd.load) begin
         read_value_ff <= read_value_in;
      end
   end

   assign dp_stat.count  = CntMaxW'(count_ff);
   assign rsp_read_value = read_value_ff;
   assign rsp_count      = CountOutW'(count_ff);

   `PIRA_ASSERT(a_count_cap, clock, reset, count_ff <= CW'(CAPACITY), "entry count above capacity")
   `PIRA_ASSERT_NEXT(a_ins_count, clock, reset, dp_cmd.ins, count_ff == $past(count_ff) + 1'b1, "insert did not grow count")
   `PIRA_ASSERT_NEXT(a_rem_count, clock, reset, dp_cmd.rem, count_ff == $past(count_ff) - 1'b1, "remove did not shrink count")

endmodule

/* tb/tb.sv */
// Self-checking testbench for the positional insert/remove array.
`timescale 1ns / 1ps
module tb;
   import pira_pkg::*;

   localparam int Slots = 16;
   localparam int RandomOps = 750;
   localparam int CycleLimit = 200000;
   localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [ValueW-1:0]    read_value;
      logic [StatusW-1:0]   status;
      logic [CountOutW-1:0] count;
   } rsp_fields_type;

   class list_tracker;
      logic [ValueW-1:0] slots[Slots];
      int unsigned fill;
      rsp_fields_type expected_rsps[$];
      int mismatches;
      int checked;
      int full_hits;
      int range_hits;

      function new();
         fill = 0;
         mismatches = 0;
         checked = 0;
         full_hits = 0;
         range_hits = 0;
      endfunction

      function rsp_fields_type apply_op(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                                        logic [ValueW-1:0] value);
         rsp_fields_type r;
         int unsigned p;
         int unsigned i;
         r = '0;
         case (cmd)
            CMD_INSERT: begin
               if (fill >= Slots) begin
                  r.status = ST_FULL;
               end else begin
                  p = (32'(pos) > fill) ? fill : 32'(pos);
                  for (i = fill; i > p; i--) slots[i] = slots[i-1];
                  slots[p] = value;
                  fill++;
               end
            end
            CMD_REMOVE: begin
               if (32'(pos) >= fill) begin
                  r.status = ST_RANGE;
               end else begin
                  for (i = 32'(pos); i + 1 < fill; i++) slots[i] = slots[i+1];
                  fill--;
               end
            end
            CMD_READ: begin
               if (32'(pos) >= fill) r.status = ST_RANGE;
               else r.read_value = slots[pos];
            end
            default: ;
         endcase
         r.count = fill[CountOutW-1:0];
         return r;
      endfunction

      function void note_op(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                            logic [ValueW-1:0] value);
         rsp_fields_type r;
         r = apply_op(cmd, pos, value);
         if (r.status == ST_FULL) full_hits++;
         if (r.status == ST_RANGE) range_hits++;
         expected_rsps.push_back(r);
      endfunction

      function void check_rsp(rsp_fields_type got);
         rsp_fields_type want;
         checked++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: value %h status %0d count %0d",
                        got.read_value, got.status, got.count);
            return;
         end
         want = expected_rsps.pop_front();
         if (got.read_value !== want.read_value || got.status !== want.status ||
             got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: want value %h status %0d count %0d, ",
                         "got value %h status %0d count %0d"},
                        want.read_value, want.status, want.count,
                        got.read_value, got.status, got.count);
         end
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [39:0]       req_tdata;
   logic [1:0]        req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [39:0]       rsp_tdata;
   logic [1:0]        rsp_tuser;

   list_tracker board;
   bit calm;
   int stall_left;
   int cycles;
   int words_sent;

   positional_insert_remove_array dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   function automatic int gap_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= gap_len();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_rsp({rsp_tdata[31:0], rsp_tuser, rsp_tdata[36:32]});
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout with %0d responses outstanding", board.pending());
         $display("positional_insert_remove_array regression: fail");
         $finish;
      end
   end

   // call at a falling edge; returns at the falling edge after acceptance, or after a gap_len() idle gap
   task automatic send_op(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                          logic [ValueW-1:0] value);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {value, pos};
      req_tuser <= cmd;
      do @(posedge clock); while (!req_tready);
      board.note_op(cmd, pos, value);
      words_sent++;
      @(negedge clock);
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   function automatic logic [PosW-1:0] pick_pos();
      if ($urandom_range(0, 9) < 7) return PosW'($urandom_range(0, board.fill));
      return PosW'($urandom_range(0, 255));
   endfunction

   function automatic logic [CmdW-1:0] pick_cmd(int mode);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return CMD_UNUSED;
      case (mode)
         0: return (r < 70) ? CMD_INSERT : (r < 85) ? CMD_REMOVE : CMD_READ;
         1: return (r < 70) ? CMD_REMOVE : (r < 85) ? CMD_INSERT : CMD_READ;
         default: return (r < 35) ? CMD_INSERT : (r < 60) ? CMD_REMOVE : CMD_READ;
      endcase
   endfunction

   initial begin
      int mode;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_INSERT;
      words_sent = 0;
      calm = 1'b0;
      board = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_op(CMD_READ, 8'd0, 32'h0);
      send_op(CMD_REMOVE, 8'd255, 32'h0);
      send_op(CMD_UNUSED, 8'd0, 32'hDEAD_BEEF);
      send_op(CMD_INSERT, 8'd255, 32'hFFFF_FFFF);
      send_op(CMD_INSERT, 8'd0, 32'h0);
      send_op(CMD_READ, 8'd1, 32'h0);
      send_op(CMD_READ, 8'd2, 32'h0);
      for (int k = 0; k < 14; k++)
         send_op(CMD_INSERT, (k % 3 == 0) ? 8'd255 : (k % 3 == 1) ? 8'd0 : 8'd3, $urandom());
      send_op(CMD_INSERT, 8'd5, 32'h1234_5678);
      send_op(CMD_READ, 8'd15, 32'h0);
      send_op(CMD_READ, 8'd16, 32'h0);
      send_op(CMD_REMOVE, 8'd15, 32'h0);
      send_op(CMD_REMOVE, 8'd0, 32'h0);
      drain();

      mode = 2;
      for (int n = 0; n < RandomOps; n++) begin
         if (n % 40 == 0) begin
            mode = $urandom_range(0, 2);
            calm = ($urandom_range(0, 3) == 0);
         end
         if (n == 250 || n == 500) drain();
         send_op(pick_cmd(mode), pick_pos(), $urandom());
      end
      calm = 1'b0;
      drain();
      repeat (4) @(negedge clock);

      $display("sent %0d words, checked %0d responses", words_sent, board.checked);
      $display("full drops %0d, out-of-range hits %0d", board.full_hits, board.range_hits);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("positional_insert_remove_array regression: pass");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("positional_insert_remove_array regression: fail");
      end
      $finish;
   end

endmodule

/* positional_insert_remove_array.f */
+incdir+src
src/pira_pkg.sv
src/pira_ctrl.sv
src/pira_dp.sv
src/positional_insert_remove_array.sv
tb/tb.sv
